// File: rtl/serial_frame_receiver_xor_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the serial frame receiver
// Implication checks on a clock with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_XOR_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_XOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SFRX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SFRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfrx_pkg.sv
// ---------------------------------------------------------------------------
// sfrx_pkg
// Constants and types shared by the serial frame receiver modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfrx_pkg;

  localparam int unsigned FrameBytes = 18;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned WordW      = 16;

  // Byte positions: first byte after the marker, and the last byte of a frame
  localparam logic [IdxW-1:0] CaptureStart = 5'd2;
  localparam logic [IdxW-1:0] LastIdx      = 5'd17;
  localparam logic [IdxW-1:0] IdleIdx      = 5'd0;

  localparam logic [WordW-1:0] MarkerReset = 16'hABCD;

  // Whole frame, byte 0 first
  typedef logic [FrameBytes-1:0][7:0] frame_t;

  // Decoded result of one frame
  typedef struct packed {
    logic             frame_ok;
    logic [WordW-1:0] command_one;
    logic [WordW-1:0] command_two;
    logic [WordW-1:0] speed_right;
    logic [WordW-1:0] speed_left;
    logic [WordW-1:0] battery_voltage;
    logic [WordW-1:0] board_temperature;
    logic [WordW-1:0] led_command;
    logic [WordW-1:0] speed_average;
  } result_t;

endpackage

// File: rtl/serial_frame_receiver_xor.sv
// ---------------------------------------------------------------------------
// serial_frame_receiver_xor
// Byte-serial receiver for 18-byte frames opened by a 16-bit start marker,
// checked by a 16-bit XOR over eight words.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        in         in_valid_i / in_ready_o   rx_byte_i
// out       out        out_valid_o / out_ready_i frame_ok_o .. speed_average_o
// cfg       in         cfg_valid_i / cfg_ready_o cfg_start_marker_i
//
// One byte is taken per cycle; the frame decode sits between the byte
// store and the result register, so a result appears the cycle after its
// last byte. Only the last byte of a frame stalls, and only while the
// previous result has not been taken. Reset clears the marker match state
// and byte index; the frame store is written before it is read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_receiver_xor (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // Result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_ok_o,
  output logic signed [15:0] command_one_o,
  output logic signed [15:0] command_two_o,
  output logic signed [15:0] speed_right_o,
  output logic signed [15:0] speed_left_o,
  output logic signed [15:0] battery_voltage_o,
  output logic signed [15:0] board_temperature_o,
  output logic        [15:0] led_command_o,
  output logic signed [15:0] speed_average_o,
  // Configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_start_marker_i
);

`include "serial_frame_receiver_xor_assert.svh"

  logic [15:0]                 marker_q;
  logic [7:0]                  prev_q;
  logic [sfrx_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [7:0]                  store_q [sfrx_pkg::FrameBytes];
  logic                        out_valid_q;
  sfrx_pkg::result_t           result_q;
  sfrx_pkg::result_t           result_d;
  sfrx_pkg::frame_t            frame;

  logic accept, marker_hit, capturing, complete;

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= sfrx_pkg::MarkerReset;
    end else if (cfg_valid_i) begin
      marker_q <= cfg_start_marker_i;
    end
  end

  // Stall only the byte that would close a frame while the result slot is full
  assign in_ready_o = !out_valid_q || out_ready_i || (idx_q != sfrx_pkg::LastIdx);
  assign accept     = in_valid_i && in_ready_o;

  assign marker_hit = ({rx_byte_i, prev_q} == marker_q);
  assign capturing  = (idx_q >= sfrx_pkg::CaptureStart) && (idx_q <= sfrx_pkg::LastIdx);
  assign complete   = accept && !marker_hit && (idx_q == sfrx_pkg::LastIdx);

  // Byte index
  always_comb begin
    if (marker_hit) begin
      idx_d = sfrx_pkg::CaptureStart;
    end else if (capturing && (idx_q != sfrx_pkg::LastIdx)) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = sfrx_pkg::IdleIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      idx_q  <= sfrx_pkg::IdleIdx;
    end else if (accept) begin
      prev_q <= rx_byte_i;
      idx_q  <= idx_d;
    end
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (marker_hit) begin
        store_q[0] <= prev_q;
        store_q[1] <= rx_byte_i;
      end else if (capturing) begin
        store_q[idx_q] <= rx_byte_i;
      end
    end
  end

  // Complete frame as seen with its last byte
  always_comb begin
    for (int i = 0; i < sfrx_pkg::FrameBytes - 1; i++) begin
      frame[i] = store_q[i];
    end
    frame[sfrx_pkg::FrameBytes-1] = rx_byte_i;
  end

  sfrx_check u_check (
    .frame_i  (frame),
    .result_o (result_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (complete) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_ok_o          = result_q.frame_ok;
  assign command_one_o       = result_q.command_one;
  assign command_two_o       = result_q.command_two;
  assign speed_right_o       = result_q.speed_right;
  assign speed_left_o        = result_q.speed_left;
  assign battery_voltage_o   = result_q.battery_voltage;
  assign board_temperature_o = result_q.board_temperature;
  assign led_command_o       = result_q.led_command;
  assign speed_average_o     = result_q.speed_average;

  // Checks
  `SFRX_ASSERT_NEXT(a_complete_gives_item, clk_i, rst_ni, complete, out_valid_q,
                    "completed frame did not produce an item")
  `SFRX_ASSERT_SAME(a_stall_only_at_last, clk_i, rst_ni, !in_ready_o,
                    (idx_q == sfrx_pkg::LastIdx) && out_valid_q,
                    "input stalled outside the frame end")
  `SFRX_ASSERT_SAME(a_index_legal, clk_i, rst_ni, 1'b1,
                    (idx_q == sfrx_pkg::IdleIdx) || capturing,
                    "byte index outside the capture range")
  `SFRX_ASSERT_SAME(a_reject_zero, clk_i, rst_ni, out_valid_q && !result_q.frame_ok,
                    (result_q.command_one == '0) && (result_q.speed_average == '0),
                    "rejected frame carries non-zero fields")

endmodule

// File: rtl/sfrx_check.sv
// ---------------------------------------------------------------------------
// sfrx_check
// Checksum test and field decode of one complete frame (combinational).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfrx_check (
  input  sfrx_pkg::frame_t  frame_i,
  output sfrx_pkg::result_t result_o
);

  logic [8:0][sfrx_pkg::WordW-1:0] word;
  logic [sfrx_pkg::WordW-1:0]      sum_xor;
  logic signed [sfrx_pkg::WordW:0] speed_sum;
  logic [sfrx_pkg::WordW:0]        speed_adj;
  logic                            match;

  // Little-endian words
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      word[i] = {frame_i[2*i+1], frame_i[2*i]};
    end
  end

  // XOR of words 0..7 against word 8
  assign sum_xor = word[0] ^ word[1] ^ word[2] ^ word[3]
                 ^ word[4] ^ word[5] ^ word[6] ^ word[7];
  assign match   = (sum_xor == word[8]);

  // Average of the wheel speeds, rounded toward zero
  assign speed_sum = $signed({word[4][sfrx_pkg::WordW-1], word[4]})
                   + $signed({word[3][sfrx_pkg::WordW-1], word[3]});
  assign speed_adj = speed_sum + {{sfrx_pkg::WordW{1'b0}}, speed_sum[sfrx_pkg::WordW]};

  // Rejected frame gives zeros throughout
  always_comb begin
    result_o = '0;
    if (match) begin
      result_o.frame_ok          = 1'b1;
      result_o.command_one       = word[1];
      result_o.command_two       = word[2];
      result_o.speed_right       = word[3];
      result_o.speed_left        = word[4];
      result_o.battery_voltage   = word[5];
      result_o.board_temperature = word[6];
      result_o.led_command       = word[7];
      result_o.speed_average     = speed_adj[sfrx_pkg::WordW:1];
    end
  end

endmodule
